FILE: design/rk4_pkg.sv
// rk4 ode stepper package: microcode word, program rom, saturation helper
`default_nettype none

package rk4_pkg;

  localparam int unsigned PC_W = 4;

  localparam logic [PC_W-1:0] PC_FIRST = 4'd0;
  localparam logic [PC_W-1:0] PC_DIV   = 4'd13;
  localparam logic [PC_W-1:0] PC_DONE  = 4'd15;

  localparam logic [2:0] OP_F     = 3'd0;
  localparam logic [2:0] OP_MUL   = 3'd1;
  localparam logic [2:0] OP_RND   = 3'd2;
  localparam logic [2:0] OP_SUM   = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;
  localparam logic [2:0] OP_APPLY = 3'd5;
  localparam logic [2:0] OP_DONE  = 3'd6;

  localparam logic [1:0] XS_CUR = 2'd0;
  localparam logic [1:0] XS_MID = 2'd1;
  localparam logic [1:0] XS_END = 2'd2;

  localparam logic [1:0] YS_NONE = 2'd0;
  localparam logic [1:0] YS_K1H  = 2'd1;
  localparam logic [1:0] YS_K2H  = 2'd2;
  localparam logic [1:0] YS_K3   = 2'd3;

  localparam logic [1:0] KS_K1 = 2'd0;
  localparam logic [1:0] KS_K2 = 2'd1;
  localparam logic [1:0] KS_K3 = 2'd2;
  localparam logic [1:0] KS_K4 = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [1:0] REG_STEP_H   = 2'd0;
  localparam logic [1:0] REG_TARGET_X = 2'd1;

  // divide by six, one 9-bit digit per cycle
  localparam int unsigned DIG_W   = 9;
  localparam int unsigned NUM_W   = 36;
  localparam logic [1:0]  DIG_LAST = 2'd3;
  localparam logic [11:0] DIV6_M  = 12'd2731;
  localparam int unsigned DIV6_SH = 14;

  localparam logic signed [63:0] WMAX = 64'sd2147483647;
  localparam logic signed [63:0] WMIN = -64'sd2147483648;

  typedef struct packed {
    logic [2:0]      op;
    logic [1:0]      xsel;
    logic [1:0]      ysel;
    logic [1:0]      ksel;
    logic            loop;
    logic [PC_W-1:0] target;
  } ucode_t;

  function automatic ucode_t uc_word(input logic [2:0] op, input logic [1:0] xsel,
                                     input logic [1:0] ysel, input logic [1:0] ksel);
    ucode_t w;
    w        = '0;
    w.op     = op;
    w.xsel   = xsel;
    w.ysel   = ysel;
    w.ksel   = ksel;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      4'd0:  w = uc_word(OP_F,   XS_CUR, YS_NONE, KS_K1);
      4'd1:  w = uc_word(OP_MUL, XS_CUR, YS_NONE, KS_K1);
      4'd2:  w = uc_word(OP_RND, XS_CUR, YS_NONE, KS_K1);
      4'd3:  w = uc_word(OP_F,   XS_MID, YS_K1H,  KS_K2);
      4'd4:  w = uc_word(OP_MUL, XS_MID, YS_K1H,  KS_K2);
      4'd5:  w = uc_word(OP_RND, XS_MID, YS_K1H,  KS_K2);
      4'd6:  w = uc_word(OP_F,   XS_MID, YS_K2H,  KS_K3);
      4'd7:  w = uc_word(OP_MUL, XS_MID, YS_K2H,  KS_K3);
      4'd8:  w = uc_word(OP_RND, XS_MID, YS_K2H,  KS_K3);
      4'd9:  w = uc_word(OP_F,   XS_END, YS_K3,   KS_K4);
      4'd10: w = uc_word(OP_MUL, XS_END, YS_K3,   KS_K4);
      4'd11: w = uc_word(OP_RND, XS_END, YS_K3,   KS_K4);
      4'd12: w = uc_word(OP_SUM, XS_CUR, YS_NONE, KS_K1);
      4'd13: begin
        w        = uc_word(OP_DIV, XS_CUR, YS_NONE, KS_K1);
        w.loop   = 1'b1;
        w.target = PC_DIV;
      end
      4'd14: w = uc_word(OP_APPLY, XS_CUR, YS_NONE, KS_K1);
      default: w = uc_word(OP_DONE, XS_CUR, YS_NONE, KS_K1);
    endcase
    return w;
  endfunction

  // bit 32 is the clamp flag, bits 31:0 the clamped word
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > WMAX) begin
      r = {1'b1, WMAX[31:0]};
    end else if (v < WMIN) begin
      r = {1'b1, WMIN[31:0]};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/rk4_ode_stepper_top.sv
// rk4 ode stepper top level: microcoded rk4 step of dy/dx = 3x + y/2 in fixed point
`default_nettype none

// One item at a time. A load item (tuser = 0) sets the point and returns it through the
// handoff step. A step item (tuser = 1) runs the 16-word program: each slope takes the
// operand form, multiply, and round and clamp steps on the one shared 32x32 multiplier,
// then come the weighted sum, the divide by six at one 9-bit digit per cycle, the point
// update and the handoff of the result; no new item is taken before that handoff.
// The next item is taken once the result has moved into the output register,
// even if the sink has not yet taken it; a result still waiting there holds the hand
// off. Configuration writes are always taken and must only be issued while the block is
// idle.
module rk4_ode_stepper_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [63:0]  in_tdata,   // start_x, start_y
  input  wire logic [0:0]   in_tuser,   // cmd
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [191:0]      out_tdata,  // point_x, point_y, slope_one..slope_four
  output logic [1:0]        out_tuser,  // reached, saturated
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam logic signed [63:0] RND_ADD = 64'sd1 <<< (FRAC_BITS - 1);

  logic                         busy_r;
  logic [rk4_pkg::PC_W-1:0]     pc_r;
  rk4_pkg::ucode_t              uc;

  logic [30:0]                  step_h_r;
  logic signed [31:0]           target_r;
  logic signed [31:0]           cur_x_r;
  logic signed [31:0]           cur_y_r;
  logic signed [31:0]           xm_r;
  logic signed [31:0]           xe_r;
  logic signed [31:0]           f_r;
  logic signed [63:0]           prod_r;
  logic signed [31:0]           k1_r;
  logic signed [31:0]           k2_r;
  logic signed [31:0]           k3_r;
  logic signed [31:0]           k4_r;
  logic                         sat_r;
  logic [rk4_pkg::NUM_W-1:0]    num_r;
  logic [rk4_pkg::NUM_W-1:0]    quo_r;
  logic [2:0]                   rem_r;
  logic                         neg_r;
  logic [1:0]                   cnt_r;
  logic                         out_valid_r;
  logic [191:0]                 out_data_r;
  logic [1:0]                   out_user_r;

  logic                         in_fire;
  logic                         done_fire;
  logic signed [63:0]           h64;
  logic signed [63:0]           x64;
  logic signed [63:0]           y64;
  logic [32:0]                  xm_nxt;
  logic [32:0]                  xe_nxt;
  logic signed [31:0]           xarg;
  logic signed [63:0]           xarg64;
  logic signed [63:0]           yadd;
  logic [32:0]                  yarg_s;
  logic signed [63:0]           yarg64;
  logic [32:0]                  f_nxt;
  logic signed [31:0]           h_s;
  logic signed [63:0]           prod_nxt;
  logic [32:0]                  k_nxt;
  logic signed [63:0]           ksum;
  logic signed [63:0]           kabs;
  logic signed [63:0]           num_nxt;
  logic [11:0]                  dig_v;
  logic [23:0]                  dig_prod;
  logic [rk4_pkg::DIG_W-1:0]    dig_q;
  logic [11:0]                  dig_six;
  logic [11:0]                  dig_rem;
  logic signed [63:0]           q64;
  logic [32:0]                  y_nxt;

  assign uc = rk4_pkg::ucode_rom(pc_r);

  assign in_tready  = !busy_r;
  assign in_fire    = in_tvalid && in_tready;
  assign done_fire  = busy_r && (uc.op == rk4_pkg::OP_DONE) && (!out_valid_r || out_tready);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // operand forming
  assign h64    = signed'({33'd0, step_h_r});
  assign x64    = 64'(cur_x_r);
  assign y64    = 64'(cur_y_r);
  assign xm_nxt = rk4_pkg::sat32(x64 + (h64 >>> 1));
  assign xe_nxt = rk4_pkg::sat32(x64 + h64);

  always_comb begin
    case (uc.xsel)
      rk4_pkg::XS_MID: xarg = xm_r;
      rk4_pkg::XS_END: xarg = xe_r;
      default:         xarg = cur_x_r;
    endcase
    case (uc.ysel)
      rk4_pkg::YS_K1H: yadd = 64'(k1_r) >>> 1;
      rk4_pkg::YS_K2H: yadd = 64'(k2_r) >>> 1;
      rk4_pkg::YS_K3:  yadd = 64'(k3_r);
      default:         yadd = 64'sd0;
    endcase
  end

  assign xarg64 = 64'(xarg);
  assign yarg_s = rk4_pkg::sat32(y64 + yadd);
  assign yarg64 = 64'(signed'(yarg_s[31:0]));
  assign f_nxt  = rk4_pkg::sat32((xarg64 <<< 1) + xarg64 + (yarg64 >>> 1));

  // shared multiplier and rounding
  assign h_s      = signed'({1'b0, step_h_r});
  assign prod_nxt = 64'(h_s) * 64'(f_r);
  assign k_nxt    = rk4_pkg::sat32((prod_r + RND_ADD) >>> FRAC_BITS);

  // weighted sum, magnitude plus three for round half away from zero
  assign ksum    = 64'(k1_r) + (64'(k2_r) <<< 1) + (64'(k3_r) <<< 1) + 64'(k4_r);
  assign kabs    = (ksum < 0) ? -ksum : ksum;
  assign num_nxt = kabs + 64'sd3;

  // one quotient digit of the divide by six
  assign dig_v    = {rem_r, num_r[rk4_pkg::NUM_W-1 -: rk4_pkg::DIG_W]};
  assign dig_prod = {12'd0, dig_v} * {12'd0, rk4_pkg::DIV6_M};
  assign dig_q    = dig_prod[rk4_pkg::DIV6_SH +: rk4_pkg::DIG_W];
  assign dig_six  = ({3'd0, dig_q} << 2) + ({3'd0, dig_q} << 1);
  assign dig_rem  = dig_v - dig_six;

  assign q64   = neg_r ? -signed'({28'd0, quo_r}) : signed'({28'd0, quo_r});
  assign y_nxt = rk4_pkg::sat32(y64 + q64);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= rk4_pkg::PC_FIRST;
      out_valid_r <= 1'b0;
      step_h_r    <= 31'd6554;
      target_r    <= 32'sd65536;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rk4_pkg::REG_STEP_H:   step_h_r <= cfg_data[30:0];
          rk4_pkg::REG_TARGET_X: target_r <= signed'(cfg_data);
          default: ;
        endcase
      end

      if (done_fire) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {k4_r, k3_r, k2_r, k1_r, cur_y_r, cur_x_r};
        out_user_r  <= {sat_r, cur_x_r >= target_r};
        busy_r      <= 1'b0;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (in_fire) begin
        busy_r <= 1'b1;
        if (in_tuser[0] == rk4_pkg::CMD_LOAD) begin
          cur_x_r <= signed'(in_tdata[31:0]);
          cur_y_r <= signed'(in_tdata[63:32]);
          k1_r    <= '0;
          k2_r    <= '0;
          k3_r    <= '0;
          k4_r    <= '0;
          sat_r   <= 1'b0;
          pc_r    <= rk4_pkg::PC_DONE;
        end else begin
          xm_r  <= signed'(xm_nxt[31:0]);
          xe_r  <= signed'(xe_nxt[31:0]);
          sat_r <= xm_nxt[32] | xe_nxt[32];
          pc_r  <= rk4_pkg::PC_FIRST;
        end
      end else if (busy_r) begin
        case (uc.op)
          rk4_pkg::OP_F: begin
            f_r   <= signed'(f_nxt[31:0]);
            sat_r <= sat_r | yarg_s[32] | f_nxt[32];
          end
          rk4_pkg::OP_MUL: begin
            prod_r <= prod_nxt;
          end
          rk4_pkg::OP_RND: begin
            sat_r <= sat_r | k_nxt[32];
            case (uc.ksel)
              rk4_pkg::KS_K1: k1_r <= signed'(k_nxt[31:0]);
              rk4_pkg::KS_K2: k2_r <= signed'(k_nxt[31:0]);
              rk4_pkg::KS_K3: k3_r <= signed'(k_nxt[31:0]);
              default:        k4_r <= signed'(k_nxt[31:0]);
            endcase
          end
          rk4_pkg::OP_SUM: begin
            num_r <= num_nxt[rk4_pkg::NUM_W-1:0];
            neg_r <= ksum < 0;
            rem_r <= 3'd0;
            quo_r <= '0;
            cnt_r <= rk4_pkg::DIG_LAST;
          end
          rk4_pkg::OP_DIV: begin
            num_r <= num_r << rk4_pkg::DIG_W;
            quo_r <= {quo_r[rk4_pkg::NUM_W-rk4_pkg::DIG_W-1:0], dig_q};
            rem_r <= dig_rem[2:0];
            cnt_r <= cnt_r - 2'd1;
          end
          rk4_pkg::OP_APPLY: begin
            cur_y_r <= signed'(y_nxt[31:0]);
            cur_x_r <= xe_r;
            sat_r   <= sat_r | y_nxt[32];
          end
          default: ;
        endcase

        if (uc.op != rk4_pkg::OP_DONE) begin
          if (uc.loop && (cnt_r != 2'd0)) begin
            pc_r <= uc.target;
          end else begin
            pc_r <= pc_r + 4'd1;
          end
        end
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> busy_r && !in_tready)
    else $error("accepted item did not start the sequencer");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r) && $past(pc_r) == rk4_pkg::PC_DONE)
    else $error("result appeared without the handoff step");

  a_div_loop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && pc_r == rk4_pkg::PC_DIV && cnt_r == 2'd0 |=> pc_r != rk4_pkg::PC_DIV)
    else $error("divide loop ran past its last digit");

endmodule

`default_nettype wire

FILE: tb/sv/rk4_ode_stepper_checker.sv
`timescale 1ns / 100ps
// rk4 ode stepper checker: follows the registers and the point, predicts and compares results
module rk4_ode_stepper_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [63:0]  in_tdata,
  input  logic [0:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [191:0] out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           failures,
  output int           outstanding,
  output int           clamped_results,
  output int           reached_results
);

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  // same bit order as {out_tuser, out_tdata}
  typedef struct packed {
    logic               saturated;
    logic               reached;
    logic signed [31:0] slope_four;
    logic signed [31:0] slope_three;
    logic signed [31:0] slope_two;
    logic signed [31:0] slope_one;
    logic signed [31:0] point_y;
    logic signed [31:0] point_x;
  } point_result_t;

  logic [30:0]        step_size;
  logic signed [31:0] target;
  logic signed [31:0] pt_x;
  logic signed [31:0] pt_y;
  logic               clamp_hit;
  int                 fail_count;
  point_result_t      expected_points[$];

  initial begin
    failures        = 0;
    outstanding     = 0;
    clamped_results = 0;
    reached_results = 0;
  end

  function automatic logic signed [31:0] clamp(input longint v);
    if (v > WORD_MAX) begin
      clamp_hit = 1'b1;
      return WORD_MAX[31:0];
    end
    if (v < WORD_MIN) begin
      clamp_hit = 1'b1;
      return WORD_MIN[31:0];
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] slope_field(input logic signed [31:0] x,
                                                    input logic signed [31:0] y);
    return clamp(3 * longint'(x) + (longint'(y) >>> 1));
  endfunction

  // h times v, rounded with halves toward +inf
  function automatic logic signed [31:0] scale_by_h(input logic signed [31:0] v);
    longint p;
    p = longint'(step_size) * longint'(v) + (longint'(1) <<< (FRAC_BITS - 1));
    return clamp(p >>> FRAC_BITS);
  endfunction

  function automatic point_result_t advance(input logic cmd, input logic signed [31:0] sx,
                                            input logic signed [31:0] sy);
    point_result_t      r;
    longint             h;
    longint             total;
    longint             mag;
    longint             quot;
    logic signed [31:0] x_mid;
    logic signed [31:0] x_end;
    r         = '0;
    clamp_hit = 1'b0;
    if (cmd == rk4_pkg::CMD_LOAD) begin
      pt_x = sx;
      pt_y = sy;
    end else begin
      h             = longint'(step_size);
      x_mid         = clamp(longint'(pt_x) + (h >>> 1));
      x_end         = clamp(longint'(pt_x) + h);
      r.slope_one   = scale_by_h(slope_field(pt_x, pt_y));
      r.slope_two   = scale_by_h(slope_field(x_mid,
                        clamp(longint'(pt_y) + (longint'(r.slope_one) >>> 1))));
      r.slope_three = scale_by_h(slope_field(x_mid,
                        clamp(longint'(pt_y) + (longint'(r.slope_two) >>> 1))));
      r.slope_four  = scale_by_h(slope_field(x_end,
                        clamp(longint'(pt_y) + longint'(r.slope_three))));
      total = longint'(r.slope_one) + 2 * longint'(r.slope_two)
            + 2 * longint'(r.slope_three) + longint'(r.slope_four);
      mag   = (total < 0) ? -total : total;
      quot  = (mag + 3) / 6;
      if (total < 0) quot = -quot;
      pt_y = clamp(longint'(pt_y) + quot);
      pt_x = x_end;
    end
    r.point_x   = pt_x;
    r.point_y   = pt_y;
    r.reached   = (pt_x >= target);
    r.saturated = clamp_hit;
    return r;
  endfunction

  task automatic note_failure(input string what, input point_result_t want,
                              input point_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%t %s", $time, what);
      $display("  want x=%h y=%h k=%h %h %h %h reached=%b sat=%b", want.point_x, want.point_y,
               want.slope_one, want.slope_two, want.slope_three, want.slope_four,
               want.reached, want.saturated);
      $display("  got  x=%h y=%h k=%h %h %h %h reached=%b sat=%b", got.point_x, got.point_y,
               got.slope_one, got.slope_two, got.slope_three, got.slope_four,
               got.reached, got.saturated);
    end
  endtask

  always @(posedge clk) begin
    point_result_t want;
    point_result_t got;
    if (!rst_n) begin
      step_size  = 31'd6554;
      target     = 32'sd65536;
      pt_x       = '0;
      pt_y       = '0;
      fail_count = 0;
      expected_points.delete();
      failures        <= 0;
      outstanding     <= 0;
      clamped_results <= 0;
      reached_results <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rk4_pkg::REG_STEP_H:   step_size = cfg_data[30:0];
          rk4_pkg::REG_TARGET_X: target    = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_points.push_back(advance(in_tuser[0], in_tdata[31:0], in_tdata[63:32]));
      end
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata};
        if (expected_points.size() == 0) begin
          note_failure("result item with nothing expected", '0, got);
        end else begin
          want = expected_points.pop_front();
          if (got !== want) note_failure("result item mismatch", want, got);
        end
        if (got.saturated === 1'b1) clamped_results <= clamped_results + 1;
        if (got.reached === 1'b1) reached_results <= reached_results + 1;
      end
      failures    <= fail_count;
      outstanding <= expected_points.size();
    end
  end

endmodule

FILE: tb/sv/rk4_ode_stepper_top_tb.sv
`timescale 1ns / 100ps
// rk4 ode stepper testbench top: clock, reset, stimulus, sink stalls and the verdict
module rk4_ode_stepper_top_tb;

  localparam logic [1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [1:0] REG_UNUSED_HI = 2'd3;
  localparam int         PHASES        = 8;
  localparam int         PHASE_ITEMS   = 225;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata   = '0;
  logic [0:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index  = '0;
  logic [31:0]  cfg_data   = '0;

  int failures;
  int outstanding;
  int clamped_results;
  int reached_results;
  int load_items  = 0;
  int step_items  = 0;
  int reg_writes  = 0;
  int stall_left  = 0;
  bit calm        = 1'b0;
  bit steady      = 1'b0;
  bit spare_flip  = 1'b0;

  rk4_ode_stepper_top #(.FRAC_BITS(16)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rk4_ode_stepper_checker #(.FRAC_BITS(16)) chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .failures        (failures),
    .outstanding     (outstanding),
    .clamped_results (clamped_results),
    .reached_results (reached_results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // sink stalls in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [31:0] pick_word();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return r;
      4:       return {{16{r[15]}}, r[15:0]};
      default: return {{12{r[19]}}, r[19:0]};
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 7))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'd1;
      2:       return 32'd0;
      3:       return 32'd65536;
      4:       return 32'd6554;
      default: return {1'($urandom), 31'($urandom_range(1, 262144))};
    endcase
  endfunction

  task automatic send_item(input logic cmd, input logic [31:0] sx, input logic [31:0] sy);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {sy, sx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == rk4_pkg::CMD_LOAD) load_items++;
    else step_items++;
    if (!calm && !steady && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  // both registers plus one write to an unused index
  task automatic program_regs(input logic [31:0] h_data, input logic [31:0] t_data);
    write_reg(rk4_pkg::REG_STEP_H, h_data);
    write_reg(rk4_pkg::REG_TARGET_X, t_data);
    write_reg(spare_flip ? REG_UNUSED_HI : REG_UNUSED_LO, $urandom);
    spare_flip = !spare_flip;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase_start;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, step straight from the reset point, then the corners
    send_item(rk4_pkg::CMD_STEP, 32'h0, 32'h0);
    send_item(rk4_pkg::CMD_LOAD, 32'h0001_0000, 32'h0001_0000);
    send_item(rk4_pkg::CMD_STEP, $urandom, $urandom);
    send_item(rk4_pkg::CMD_STEP, $urandom, $urandom);
    send_item(rk4_pkg::CMD_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(rk4_pkg::CMD_STEP, $urandom, $urandom);
    send_item(rk4_pkg::CMD_LOAD, 32'h8000_0000, 32'h8000_0000);
    send_item(rk4_pkg::CMD_STEP, $urandom, $urandom);
    send_item(rk4_pkg::CMD_LOAD, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(rk4_pkg::CMD_STEP, $urandom, $urandom);
    send_item(rk4_pkg::CMD_LOAD, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(rk4_pkg::CMD_STEP, $urandom, $urandom);
    send_item(rk4_pkg::CMD_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(rk4_pkg::CMD_STEP, $urandom, $urandom);
    drain();

    // zero step, lowest target
    program_regs(32'h0, 32'h8000_0000);
    send_item(rk4_pkg::CMD_LOAD, 32'h0005_0000, 32'hFFFD_0000);
    send_item(rk4_pkg::CMD_STEP, $urandom, $urandom);
    send_item(rk4_pkg::CMD_STEP, $urandom, $urandom);
    drain();

    // largest step with the dropped top bit set, highest target
    program_regs(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_item(rk4_pkg::CMD_LOAD, 32'h0001_0000, 32'h0001_0000);
    send_item(rk4_pkg::CMD_STEP, $urandom, $urandom);
    send_item(rk4_pkg::CMD_LOAD, 32'h7FFF_0000, 32'h0);
    send_item(rk4_pkg::CMD_STEP, $urandom, $urandom);
    drain();

    // smallest nonzero step, target at zero
    program_regs(32'h1, 32'h0);
    send_item(rk4_pkg::CMD_LOAD, 32'hFFFF_FFFF, 32'h0);
    send_item(rk4_pkg::CMD_STEP, $urandom, $urandom);
    send_item(rk4_pkg::CMD_STEP, $urandom, $urandom);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      calm = (phase == PHASES - 1);
      program_regs(pick_step(), pick_word());
      phase_start = load_items + step_items;
      while (load_items + step_items - phase_start < PHASE_ITEMS) begin
        steady = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 9) == 0) begin
          send_item(1'($urandom), $urandom, $urandom);
        end else begin
          send_item(rk4_pkg::CMD_LOAD, pick_word(), pick_word());
          repeat ($urandom_range(1, 24)) send_item(rk4_pkg::CMD_STEP, $urandom, $urandom);
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("run covered %0d load and %0d step items with %0d register writes",
             load_items, step_items, reg_writes);
    $display("%0d results came back clamped, %0d with the target reached",
             clamped_results, reached_results);
    if (failures == 0) begin
      $display("rk4_ode_stepper_top_tb: clean");
    end else begin
      $display("rk4_ode_stepper_top_tb: errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d results still outstanding", outstanding);
    $display("rk4_ode_stepper_top_tb: errors");
    $finish;
  end

endmodule

FILE: sim.f
design/rk4_pkg.sv
design/rk4_ode_stepper_top.sv
tb/sv/rk4_ode_stepper_checker.sv
tb/sv/rk4_ode_stepper_top_tb.sv
